### hdl/sdrd_pkg.sv
// Package for the SD SPI block read receiver: codes, field widths, shared types.
// Used by sdrd_out_if and every module of the block; depends on nothing.
package sdrd_pkg;

  localparam int unsigned MAX_BLOCK_BYTES = 4096;

  localparam int unsigned BLOCK_LEN_W = 13;
  localparam int unsigned WAIT_W      = 8;
  localparam int unsigned BYTE_IDX_W  = 12;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [BLOCK_LEN_W-1:0] BLOCK_LEN_RESET = 13'd512;
  localparam logic [WAIT_W-1:0]      WAIT_LIMIT_RESET = 8'd20;

  localparam logic [7:0]  START_TOKEN = 8'hFE;
  localparam logic [15:0] CRC_POLY    = 16'h1021;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TOKEN_WAIT   = 1'b1;

  localparam logic KIND_ARM  = 1'b0;
  localparam logic KIND_BYTE = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TOKEN,
    PH_DATA,
    PH_CRC_HI,
    PH_CRC_LO
  } phase_e;

  typedef enum logic [1:0] {
    EV_DATA    = 2'd0,
    EV_OK      = 2'd1,
    EV_BAD_CRC = 2'd2,
    EV_TIMEOUT = 2'd3
  } event_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    event_e                event_res;
    logic [7:0]            data_byte;
    logic [BYTE_IDX_W-1:0] byte_index;
  } result_t;

  typedef struct packed {
    logic [BLOCK_LEN_W-1:0] block_length;
    logic [WAIT_W-1:0]      token_wait_limit;
  } cfg_t;

endpackage

### hdl/sdrd_if.sv
// Valid/ready stream interfaces for the byte input and the event output.
// Depends on sdrd_pkg for field widths.
interface sdrd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface sdrd_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     event_res;
  logic [7:0]                     data_byte;
  logic [sdrd_pkg::BYTE_IDX_W-1:0] byte_index;

  modport source (output valid, output event_res, output data_byte, output byte_index,
                  input ready);
  modport sink (input valid, input event_res, input data_byte, input byte_index,
                output ready);
endinterface

### hdl/sdrd_crc_byte.sv
// One-byte update of CRC-16 (poly 0x1021, MSB first, no reflection).
// Depends on sdrd_pkg for the polynomial.
module sdrd_crc_byte (
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {byte_i, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ sdrd_pkg::CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

### hdl/sdrd_core.sv
// Block reception state machine: token scan with timeout, data count, CRC check.
// Depends on sdrd_pkg and sdrd_crc_byte.
module sdrd_core #(
  parameter int unsigned MAX_BLOCK_BYTES = sdrd_pkg::MAX_BLOCK_BYTES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  sdrd_pkg::item_t   item_i,
  input  sdrd_pkg::cfg_t    cfg_i,
  output logic              res_valid_o,
  output sdrd_pkg::result_t res_o
);

  localparam int unsigned CW = $clog2(MAX_BLOCK_BYTES + 1);
  localparam int unsigned LW = (CW > sdrd_pkg::BLOCK_LEN_W) ? CW : sdrd_pkg::BLOCK_LEN_W;
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_BLOCK_BYTES);

  sdrd_pkg::phase_e phase_q, phase_d;
  logic [sdrd_pkg::WAIT_W-1:0] wait_q, wait_d;
  logic [CW-1:0]    byte_cnt_q, byte_cnt_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       crc_hi_q, crc_hi_d;

  logic [15:0]      crc_next;
  logic [LW-1:0]    eff_len;
  logic [sdrd_pkg::WAIT_W-1:0] limit;
  logic [sdrd_pkg::WAIT_W-1:0] wait_inc;
  logic [CW-1:0]    byte_inc;

  sdrd_crc_byte u_crc (
    .crc_i  (crc_q),
    .byte_i (item_i.rx_byte),
    .crc_o  (crc_next)
  );

  // Zero length acts as one, oversize saturates.
  always_comb begin
    eff_len = LW'(cfg_i.block_length);
    if (eff_len == '0) begin
      eff_len = LW'(1);
    end
    if (eff_len > MAX_LEN) begin
      eff_len = MAX_LEN;
    end
  end

  assign limit    = (cfg_i.token_wait_limit == '0) ? sdrd_pkg::WAIT_W'(1)
                                                   : cfg_i.token_wait_limit;
  assign wait_inc = wait_q + sdrd_pkg::WAIT_W'(1);
  assign byte_inc = byte_cnt_q + CW'(1);

  always_comb begin
    phase_d     = phase_q;
    wait_d      = wait_q;
    byte_cnt_d  = byte_cnt_q;
    crc_d       = crc_q;
    crc_hi_d    = crc_hi_q;
    res_valid_o = 1'b0;
    res_o       = '{event_res: sdrd_pkg::EV_DATA, data_byte: 8'h00, byte_index: '0};

    if (item_i.kind == sdrd_pkg::KIND_ARM) begin
      // Arm restarts a scan, abandoning any block in progress.
      phase_d    = sdrd_pkg::PH_TOKEN;
      wait_d     = '0;
      byte_cnt_d = '0;
      crc_d      = '0;
      crc_hi_d   = '0;
    end else begin
      case (phase_q)
        sdrd_pkg::PH_IDLE: begin
        end
        sdrd_pkg::PH_TOKEN: begin
          if (item_i.rx_byte == sdrd_pkg::START_TOKEN) begin
            phase_d    = sdrd_pkg::PH_DATA;
            byte_cnt_d = '0;
            crc_d      = '0;
          end else begin
            wait_d = wait_inc;
            if (wait_inc >= limit) begin
              phase_d         = sdrd_pkg::PH_IDLE;
              res_valid_o     = 1'b1;
              res_o.event_res = sdrd_pkg::EV_TIMEOUT;
            end
          end
        end
        sdrd_pkg::PH_DATA: begin
          crc_d            = crc_next;
          res_valid_o      = 1'b1;
          res_o.data_byte  = item_i.rx_byte;
          res_o.byte_index = sdrd_pkg::BYTE_IDX_W'(byte_cnt_q);
          byte_cnt_d       = byte_inc;
          if (LW'(byte_inc) >= eff_len) begin
            phase_d = sdrd_pkg::PH_CRC_HI;
          end
        end
        sdrd_pkg::PH_CRC_HI: begin
          crc_hi_d = item_i.rx_byte;
          phase_d  = sdrd_pkg::PH_CRC_LO;
        end
        sdrd_pkg::PH_CRC_LO: begin
          phase_d     = sdrd_pkg::PH_IDLE;
          res_valid_o = 1'b1;
          res_o.event_res = ({crc_hi_q, item_i.rx_byte} == crc_q) ? sdrd_pkg::EV_OK
                                                                  : sdrd_pkg::EV_BAD_CRC;
        end
        default: begin
          phase_d = sdrd_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= sdrd_pkg::PH_IDLE;
      wait_q     <= '0;
      byte_cnt_q <= '0;
      crc_q      <= '0;
      crc_hi_q   <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      wait_q     <= wait_d;
      byte_cnt_q <= byte_cnt_d;
      crc_q      <= crc_d;
      crc_hi_q   <= crc_hi_d;
    end
  end

endmodule

### hdl/sd_spi_block_read_receiver.sv
// SD SPI data block receiver, read path. Accepts one byte item per clock while the
// result register is not blocked, and returns at most one event per item: each data
// byte with its index, then CRC ok or mismatch, or a token timeout. An item passes an
// input register and then a result register, where its event is held until taken; the
// one-byte CRC-16 update sits between those registers. Configure block_length and
// token_wait_limit only while no item is in flight.
// Depends on sdrd_pkg, sdrd_if, sdrd_crc_byte and sdrd_core.
module sd_spi_block_read_receiver #(
  parameter int unsigned MAX_BLOCK_BYTES = sdrd_pkg::MAX_BLOCK_BYTES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  sdrd_in_if.sink                            in_i,
  sdrd_out_if.source                         out_o,
  input  logic                               cfg_we_i,
  input  logic [sdrd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sdrd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  sdrd_pkg::cfg_t    cfg_q, cfg_d;
  logic              s1_valid_q, s1_valid_d;
  sdrd_pkg::item_t   s1_item_q;
  logic              out_valid_q, out_valid_d;
  sdrd_pkg::result_t out_res_q;

  logic              out_free;
  logic              s1_adv;
  logic              in_xfer;
  logic              res_valid;
  sdrd_pkg::result_t res;

  assign out_free  = !out_valid_q || out_o.ready;
  assign s1_adv    = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_xfer   = in_i.valid && in_i.ready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        sdrd_pkg::REG_BLOCK_LENGTH: cfg_d.block_length = cfg_data_i;
        sdrd_pkg::REG_TOKEN_WAIT:   cfg_d.token_wait_limit = cfg_data_i[sdrd_pkg::WAIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{block_length: sdrd_pkg::BLOCK_LEN_RESET,
                 token_wait_limit: sdrd_pkg::WAIT_LIMIT_RESET};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Input register: hold while the result register is blocked.
  assign s1_valid_d = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q <= '{kind: in_i.kind, rx_byte: in_i.rx_byte};
    end
  end

  sdrd_core #(
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s1_adv),
    .item_i      (s1_item_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register: items without an event still drain through.
  assign out_valid_d = out_free ? (s1_adv && res_valid) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_adv && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.event_res  = out_res_q.event_res;
  assign out_o.data_byte  = out_res_q.data_byte;
  assign out_o.byte_index = out_res_q.byte_index;

  a_ready_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled while result register is free");

  a_load_from_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_adv))
    else $error("result appeared without an input stage advance");

  a_status_no_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.event_res != sdrd_pkg::EV_DATA)
      |-> (out_res_q.data_byte == 8'h00 && out_res_q.byte_index == '0))
    else $error("status event carries nonzero payload");

endmodule

### test/tb.sv
// Testbench for sd_spi_block_read_receiver: directed table, then random SPI block traffic.
// Expected events come from an in-bench receiver predictor or typed table rows; depends on sdrd_pkg and sdrd_if.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS   = 1750;
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES  = 120;

  typedef enum {CHK_MODEL, CHK_TYPED, CHK_NONE} chk_e;

  typedef struct {
    bit                               is_cfg;
    logic                             kind;
    logic [7:0]                       rx_byte;
    chk_e                             chk;
    sdrd_pkg::result_t                want;
    logic [sdrd_pkg::BLOCK_LEN_W-1:0] len;
    logic [sdrd_pkg::WAIT_W-1:0]      lim;
  } row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [sdrd_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [sdrd_pkg::CFG_DATA_W-1:0] cfg_data_i;

  sdrd_in_if  in_if ();
  sdrd_out_if out_if ();

  sd_spi_block_read_receiver u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // receiver predictor state and its copy of the registers
  sdrd_pkg::phase_e                 rx_phase;
  logic [sdrd_pkg::WAIT_W-1:0]      tok_wait;
  int                               data_cnt;
  logic [15:0]                      crc_run;
  logic [7:0]                       crc_hi_q;
  logic [sdrd_pkg::BLOCK_LEN_W-1:0] cfg_block_len;
  logic [sdrd_pkg::WAIT_W-1:0]      cfg_wait_lim;

  sdrd_pkg::result_t events_due[$];
  row_t              dir_rows[$];
  int                n_err;
  int                n_items;
  bit                idle_on;
  bit                hold_req;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] d);
    c = c ^ {d, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ sdrd_pkg::CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic int eff_len();
    int n;
    n = cfg_block_len;
    if (n == 0) n = 1;
    if (n > sdrd_pkg::MAX_BLOCK_BYTES) n = sdrd_pkg::MAX_BLOCK_BYTES;
    return n;
  endfunction

  function automatic int eff_lim();
    int n;
    n = cfg_wait_lim;
    if (n == 0) n = 1;
    return n;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  // any byte except the start token
  function automatic logic [7:0] scan_noise();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == sdrd_pkg::START_TOKEN) b = 8'h00;
    return b;
  endfunction

  function automatic bit receiver_step(logic k, logic [7:0] b, output sdrd_pkg::result_t r);
    r = '0;
    if (k == sdrd_pkg::KIND_ARM) begin
      rx_phase = sdrd_pkg::PH_TOKEN;
      tok_wait = '0;
      data_cnt = 0;
      crc_run  = '0;
      crc_hi_q = '0;
      return 1'b0;
    end
    case (rx_phase)
      sdrd_pkg::PH_TOKEN: begin
        if (b == sdrd_pkg::START_TOKEN) begin
          rx_phase = sdrd_pkg::PH_DATA;
          data_cnt = 0;
          crc_run  = '0;
          return 1'b0;
        end
        tok_wait = tok_wait + 8'd1;
        if (int'(tok_wait) >= eff_lim()) begin
          rx_phase    = sdrd_pkg::PH_IDLE;
          r.event_res = sdrd_pkg::EV_TIMEOUT;
          return 1'b1;
        end
        return 1'b0;
      end
      sdrd_pkg::PH_DATA: begin
        crc_run      = crc16_step(crc_run, b);
        r.event_res  = sdrd_pkg::EV_DATA;
        r.data_byte  = b;
        r.byte_index = sdrd_pkg::BYTE_IDX_W'(data_cnt);
        data_cnt++;
        if (data_cnt >= eff_len()) rx_phase = sdrd_pkg::PH_CRC_HI;
        return 1'b1;
      end
      sdrd_pkg::PH_CRC_HI: begin
        crc_hi_q = b;
        rx_phase = sdrd_pkg::PH_CRC_LO;
        return 1'b0;
      end
      sdrd_pkg::PH_CRC_LO: begin
        rx_phase    = sdrd_pkg::PH_IDLE;
        r.event_res = ({crc_hi_q, b} == crc_run) ? sdrd_pkg::EV_OK : sdrd_pkg::EV_BAD_CRC;
        return 1'b1;
      end
      default: begin
        rx_phase = sdrd_pkg::PH_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void add_row(logic k, logic [7:0] b, chk_e chk = CHK_NONE,
                                  sdrd_pkg::event_e ev = sdrd_pkg::EV_DATA,
                                  logic [7:0] d = 8'h00,
                                  logic [sdrd_pkg::BYTE_IDX_W-1:0] idx = '0);
    row_t r;
    r.is_cfg  = 1'b0;
    r.kind    = k;
    r.rx_byte = b;
    r.chk     = chk;
    r.want    = '0;
    r.len     = '0;
    r.lim     = '0;
    r.want.event_res  = ev;
    r.want.data_byte  = d;
    r.want.byte_index = idx;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_cfg(logic [sdrd_pkg::BLOCK_LEN_W-1:0] len,
                                  logic [sdrd_pkg::WAIT_W-1:0] lim);
    row_t r;
    r.is_cfg  = 1'b1;
    r.kind    = sdrd_pkg::KIND_ARM;
    r.rx_byte = 8'h00;
    r.chk     = CHK_NONE;
    r.want    = '0;
    r.len     = len;
    r.lim     = lim;
    dir_rows.push_back(r);
  endfunction

  task automatic send_item(logic k, logic [7:0] b, chk_e chk, sdrd_pkg::result_t want);
    sdrd_pkg::result_t r;
    bit                has;
    sdrd_pkg::phase_e  ph0;
    in_if.valid   <= 1'b1;
    in_if.kind    <= k;
    in_if.rx_byte <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    ph0 = rx_phase;
    has = receiver_step(k, b, r);
    if (chk == CHK_MODEL && has) events_due.push_back(r);
    if (chk == CHK_TYPED) events_due.push_back(want);
    if (k == sdrd_pkg::KIND_ARM || ph0 != sdrd_pkg::PH_IDLE) n_items++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(sdrd_pkg::KIND_BYTE, b, CHK_MODEL, '0);
  endtask

  task automatic send_arm();
    send_item(sdrd_pkg::KIND_ARM, rand_byte(), CHK_MODEL, '0);
  endtask

  // drop valid, wait for every pending event, then let the pipeline empty
  task automatic settle();
    in_if.valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [sdrd_pkg::BLOCK_LEN_W-1:0] len,
                            logic [sdrd_pkg::WAIT_W-1:0] lim);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sdrd_pkg::REG_BLOCK_LENGTH;
    cfg_data_i <= len;
    @(posedge clk_i);
    cfg_idx_i  <= sdrd_pkg::REG_TOKEN_WAIT;
    cfg_data_i <= {5'($urandom), lim};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_block_len = len;
    cfg_wait_lim  = lim;
  endtask

  function automatic logic [sdrd_pkg::BLOCK_LEN_W-1:0] pick_len();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 13'd1;
      2: return sdrd_pkg::BLOCK_LEN_W'($urandom_range(17, 64));
      default: return sdrd_pkg::BLOCK_LEN_W'($urandom_range(2, 16));
    endcase
  endfunction

  function automatic logic [sdrd_pkg::WAIT_W-1:0] pick_lim();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 8'd1;
      2: return 8'd255;
      default: return sdrd_pkg::WAIT_W'($urandom_range(2, 24));
    endcase
  endfunction

  // one read block: arm, token scan, data, CRC; may time out, break off or carry a bad CRC
  task automatic run_block(bit full);
    int          lim_n;
    int          len_n;
    int          pre;
    int          cut;
    logic [15:0] crc;
    logic [7:0]  b;
    lim_n = eff_lim();
    len_n = eff_len();
    send_arm();
    case ($urandom_range(0, 7))
      0: pre = full ? 0 : lim_n;
      1: pre = lim_n - 1;
      default: pre = $urandom_range(0, (lim_n > 4) ? 4 : lim_n - 1);
    endcase
    repeat (pre) send_byte(scan_noise());
    if (pre == lim_n) return;
    send_byte(sdrd_pkg::START_TOKEN);
    cut = (!full && $urandom_range(0, 9) == 0) ? $urandom_range(0, len_n) : len_n + 1;
    crc = '0;
    for (int i = 0; i < len_n; i++) begin
      if (i == cut) return;
      b   = rand_byte();
      crc = crc16_step(crc, b);
      send_byte(b);
    end
    if (cut == len_n) return;
    if ($urandom_range(0, 4) == 0) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    send_byte(crc[15:8]);
    send_byte(crc[7:0]);
  endtask

  // leave a block in its data phase so the next register write lands mid-block
  task automatic partial_block(int n);
    send_arm();
    send_byte(sdrd_pkg::START_TOKEN);
    repeat (n) send_byte(rand_byte());
  endtask

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        out_if.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    sdrd_pkg::result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (events_due.size() == 0) begin
        n_err++;
        if (n_err <= 200)
          $display("%0t: unexpected event: expected none, got ev=%0d data=%02h idx=%0d",
                   $time, out_if.event_res, out_if.data_byte, out_if.byte_index);
      end else begin
        want = events_due.pop_front();
        if (want.event_res !== out_if.event_res || want.data_byte !== out_if.data_byte ||
            want.byte_index !== out_if.byte_index) begin
          n_err++;
          if (n_err <= 200)
            $display({"%0t: event mismatch: expected ev=%0d data=%02h idx=%0d,",
                      " got ev=%0d data=%02h idx=%0d"},
                     $time, want.event_res, want.data_byte, want.byte_index,
                     out_if.event_res, out_if.data_byte, out_if.byte_index);
        end
      end
    end
  end

  initial begin
    #(10_000_000);
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [15:0]                      crc_demo;
    logic [sdrd_pkg::BLOCK_LEN_W-1:0] len;
    logic [sdrd_pkg::WAIT_W-1:0]      lim;
    bit                               tail;
    int                               s;

    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.kind    <= sdrd_pkg::KIND_ARM;
    in_if.rx_byte <= 8'h00;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= sdrd_pkg::REG_BLOCK_LENGTH;
    cfg_data_i    <= '0;
    cfg_block_len = sdrd_pkg::BLOCK_LEN_RESET;
    cfg_wait_lim  = sdrd_pkg::WAIT_LIMIT_RESET;
    rx_phase      = sdrd_pkg::PH_IDLE;
    tok_wait      = '0;
    data_cnt      = 0;
    crc_run       = '0;
    crc_hi_q      = '0;
    n_err         = 0;
    n_items       = 0;
    idle_on       = 1'b1;
    hold_req      = 1'b0;
    tail          = 1'b0;

    crc_demo = crc16_step(crc16_step(16'h0000, 8'h55), 8'h80);

    // reset settings: stray byte while idle, then a block under way
    add_row(sdrd_pkg::KIND_BYTE, sdrd_pkg::START_TOKEN);
    add_row(sdrd_pkg::KIND_ARM, 8'h00);
    add_row(sdrd_pkg::KIND_BYTE, 8'h00);
    add_row(sdrd_pkg::KIND_BYTE, sdrd_pkg::START_TOKEN);
    add_row(sdrd_pkg::KIND_BYTE, 8'hFF, CHK_TYPED, sdrd_pkg::EV_DATA, 8'hFF, 12'd0);
    add_row(sdrd_pkg::KIND_BYTE, 8'h00, CHK_TYPED, sdrd_pkg::EV_DATA, 8'h00, 12'd1);
    // shrink the length under the running count: data ends after one more byte
    add_cfg(13'd2, 8'd2);
    add_row(sdrd_pkg::KIND_BYTE, 8'h3C, CHK_TYPED, sdrd_pkg::EV_DATA, 8'h3C, 12'd2);
    add_row(sdrd_pkg::KIND_ARM, 8'hFF);
    add_row(sdrd_pkg::KIND_BYTE, 8'h01);
    add_row(sdrd_pkg::KIND_BYTE, sdrd_pkg::START_TOKEN);
    add_row(sdrd_pkg::KIND_BYTE, 8'hAA, CHK_TYPED, sdrd_pkg::EV_DATA, 8'hAA, 12'd0);
    add_row(sdrd_pkg::KIND_ARM, 8'h5A);
    add_row(sdrd_pkg::KIND_BYTE, sdrd_pkg::START_TOKEN);
    add_row(sdrd_pkg::KIND_BYTE, 8'h55, CHK_TYPED, sdrd_pkg::EV_DATA, 8'h55, 12'd0);
    add_row(sdrd_pkg::KIND_BYTE, 8'h80, CHK_MODEL);
    add_row(sdrd_pkg::KIND_BYTE, crc_demo[15:8]);
    add_row(sdrd_pkg::KIND_BYTE, crc_demo[7:0], CHK_TYPED, sdrd_pkg::EV_OK);
    add_row(sdrd_pkg::KIND_ARM, 8'h00);
    add_row(sdrd_pkg::KIND_BYTE, 8'h00);
    add_row(sdrd_pkg::KIND_BYTE, 8'h7F, CHK_TYPED, sdrd_pkg::EV_TIMEOUT);
    // zero length and zero wait limit both act as one
    add_cfg(13'd0, 8'd0);
    add_row(sdrd_pkg::KIND_ARM, 8'h00);
    add_row(sdrd_pkg::KIND_BYTE, 8'hFF, CHK_TYPED, sdrd_pkg::EV_TIMEOUT);
    add_row(sdrd_pkg::KIND_ARM, 8'h00);
    add_row(sdrd_pkg::KIND_BYTE, sdrd_pkg::START_TOKEN);
    add_row(sdrd_pkg::KIND_BYTE, 8'hFF, CHK_MODEL);
    add_row(sdrd_pkg::KIND_BYTE, 8'h00);
    add_row(sdrd_pkg::KIND_BYTE, 8'h00, CHK_TYPED, sdrd_pkg::EV_BAD_CRC);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle();
        write_regs(dir_rows[i].len, dir_rows[i].lim);
      end else begin
        send_item(dir_rows[i].kind, dir_rows[i].rx_byte, dir_rows[i].chk, dir_rows[i].want);
      end
    end

    n_items = 0;
    for (s = 0; n_items < RAND_ITEMS; s++) begin
      lim = pick_lim();
      if (s == 2) len = 13'd16;
      else if (s == 3) len = 13'd8191;
      else if (s == 5) len = 13'd4096;
      else len = pick_len();
      settle();
      write_regs(len, lim);
      idle_on = (n_items < RAND_ITEMS - 250) && ($urandom_range(0, 3) != 0);
      // stall the event side for a long stretch while bytes are still offered
      if (s == 2) hold_req = 1'b1;
      if (tail) repeat (eff_len() + 3) send_byte(rand_byte());
      tail = 1'b0;
      if (s == 3 || s == 5) begin
        partial_block(40);
        tail = 1'b1;
      end else begin
        repeat ($urandom_range(2, 6)) begin
          run_block(1'b0);
          if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_byte(rand_byte());
        end
        if ($urandom_range(0, 5) == 0) begin
          partial_block($urandom_range(0, eff_len() - 1));
          tail = 1'b1;
        end
      end
    end

    settle();
    if (n_err == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sd_spi_block_read_receiver.f
hdl/sdrd_pkg.sv
hdl/sdrd_if.sv
hdl/sdrd_crc_byte.sv
hdl/sdrd_core.sv
hdl/sd_spi_block_read_receiver.sv
test/tb.sv
